// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// File: hw/rtl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned RkWordsDefault = 60;
  localparam int unsigned FullWords      = 60;

  typedef enum logic [2:0] {
    CfgKeyLength = 3'd0,
    CfgKey0      = 3'd1,
    CfgKey1      = 3'd2,
    CfgKey2      = 3'd3,
    CfgKey3      = 3'd4
  } cfg_idx_e;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    sub_word = {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aes_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// AES-128/192/256 single-block cipher. One item is a 16-byte block plus a
// direction bit; the result is the enciphered or deciphered block. After
// reset or any key or key-length write, the next item first expands the key
// schedule one 32-bit word per cycle into a word RAM. Each round key is then
// fetched as four RAM reads and applied through one shared round unit. The
// result sits in an output register until taken and no new item is accepted
// before that. Key length three acts as a 128-bit key.
module aes_block_cipher #(
  parameter int unsigned RoundKeyWords = aes_pkg::RkWordsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // data_hi, data_lo
  input  wire logic         s_axis_tuser,   // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata    // result_hi, result_lo
);
  import aes_pkg::*;

  localparam int unsigned AW = $clog2(FullWords);

  typedef enum logic [2:0] {
    StIdle, StExpand, StLoad, StRound, StOut
  } state_e;

  state_e        state_q;
  logic [1:0]    klen_q;
  logic [63:0]   key_q [4];
  logic          sched_valid_q;
  logic          dec_q;
  logic [127:0]  blk_q, rk_q;
  logic [AW-1:0] wi_q;           // expansion word index
  logic [255:0]  win_q;          // last eight words, newest at low end
  logic [2:0]    km_q;           // i mod nk
  logic [7:0]    rcon_q;
  logic [3:0]    nr_q;
  logic [3:0]    kr_q;           // round key being fetched
  logic [3:0]    step_q;         // round keys applied so far
  logic [2:0]    ph_q;           // fetch phase within one round key
  logic          rd_ok_q;

  logic [3:0]    nr;
  logic [3:0]    nk;
  logic [AW:0]   total;
  logic [31:0]   prev, older, t, neww, kword, wdata;
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] raddr;
  logic [127:0]  round_out;
  logic          last_round;

  always_comb begin
    unique case (klen_q)
      2'd1:    begin nr = 4'd12; nk = 4'd6; end
      2'd2:    begin nr = 4'd14; nk = 4'd8; end
      default: begin nr = 4'd10; nk = 4'd4; end
    endcase
    total = (AW+1)'(4 * (nr + 1));
    prev  = win_q[31:0];
    unique case (nk)
      4'd6:    older = win_q[191:160];
      4'd8:    older = win_q[255:224];
      default: older = win_q[127:96];
    endcase
    if (km_q == 3'd0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && km_q == 3'd4) begin
      t = sub_word(prev);
    end else begin
      t = prev;
    end
    neww  = older ^ t;
    kword = wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32];
    wdata = (wi_q < AW'(nk)) ? kword : neww;
  end

  // Words beyond the store are still expanded but not kept; they read as zero.
  assign we         = (state_q == StExpand) && (32'(wi_q) < RoundKeyWords);
  assign raddr      = AW'({kr_q, ph_q[1:0]});
  assign last_round = (step_q == nr_q);

  aes_ram #(.Width(32), .Depth(FullWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wi_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  aes_round u_round (
    .dec_i      (dec_q),
    .skip_mix_i (last_round),
    .state_i    (blk_q),
    .rkey_i     (rk_q),
    .state_o    (round_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      klen_q <= '0;
      key_q <= '{default: '0};
      sched_valid_q <= 1'b0;
      dec_q <= 1'b0;
      wi_q <= '0; win_q <= '0; km_q <= '0; rcon_q <= 8'h01; nr_q <= 4'd10;
      kr_q <= '0; step_q <= '0; ph_q <= '0;
      rd_ok_q <= 1'b0;
      blk_q <= '0; rk_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgKeyLength: begin klen_q <= cfg_data_i[1:0]; sched_valid_q <= 1'b0; end
          CfgKey0: begin key_q[0] <= cfg_data_i; sched_valid_q <= 1'b0; end
          CfgKey1: begin key_q[1] <= cfg_data_i; sched_valid_q <= 1'b0; end
          CfgKey2: begin key_q[2] <= cfg_data_i; sched_valid_q <= 1'b0; end
          CfgKey3: begin key_q[3] <= cfg_data_i; sched_valid_q <= 1'b0; end
          default: ;
        endcase
      end
      // Read data is registered in the RAM, so its range flag is registered to match.
      rd_ok_q <= 32'(raddr) < RoundKeyWords;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            dec_q  <= s_axis_tuser;
            blk_q  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            nr_q   <= nr;
            kr_q   <= s_axis_tuser ? nr : '0;
            step_q <= '0;
            ph_q   <= '0;
            wi_q   <= '0;
            km_q   <= '0;
            rcon_q <= 8'h01;
            state_q <= sched_valid_q ? StLoad : StExpand;
          end
        end
        StExpand: begin
          wi_q  <= wi_q + 1'b1;
          win_q <= {win_q[223:0], wdata};
          if (wi_q >= AW'(nk)) begin
            if (km_q == 3'd0) rcon_q <= xtime(rcon_q);
            km_q <= (km_q == 3'(nk - 4'd1)) ? '0 : km_q + 3'd1;
          end
          if ({1'b0, wi_q} == total - 1'b1) begin
            sched_valid_q <= 1'b1;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          if (ph_q != 3'd0) begin
            rk_q <= {rk_q[95:0], rd_ok_q ? rdata : 32'h0};
          end
          if (ph_q == 3'd4) state_q <= StRound;
          ph_q <= ph_q + 3'd1;
        end
        StRound: begin
          if (step_q == 4'd0) begin
            blk_q <= blk_q ^ rk_q;
          end else begin
            blk_q <= round_out;
          end
          if (last_round) begin
            state_q <= StOut;
          end else begin
            step_q  <= step_q + 4'd1;
            kr_q    <= dec_q ? kr_q - 4'd1 : kr_q + 4'd1;
            ph_q    <= '0;
            state_q <= StLoad;
          end
        end
        StOut: begin
          if (m_axis_tready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {blk_q[63:0], blk_q[127:64]};
endmodule
`default_nettype wire

// File: hw/rtl/aes_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 60
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/aes_round.sv
`timescale 1ns / 1ps
`default_nettype none
// One cipher round, combinational. State byte n is bits 127-8n.
module aes_round (
  input  wire logic         dec_i,
  input  wire logic         skip_mix_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rkey_i,
  output logic      [127:0] state_o
);
  import aes_pkg::*;

  logic [7:0] s  [16];
  logic [7:0] sr [16];
  logic [7:0] sb [16];
  logic [7:0] ak [16];
  logic [7:0] mx [16];
  logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_i) begin
          sr[4*c+r] = s[4*((c+4-r)%4)+r];
        end else begin
          sr[4*c+r] = s[4*((c+r)%4)+r];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = dec_i ? inv_sbox(sr[i]) : sbox(sr[i]);
    end
    // Encrypt: mix then add key. Decrypt: add key then inverse mix.
    for (int i = 0; i < 16; i++) begin
      ak[i] = dec_i ? (sb[i] ^ rkey_i[127-8*i -: 8]) : sb[i];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = ak[4*c]; a1 = ak[4*c+1]; a2 = ak[4*c+2]; a3 = ak[4*c+3];
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      if (dec_i) begin
        mx[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        mx[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        mx[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        mx[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
      end else begin
        mx[4*c]   = x0 ^ (x1^a1) ^ a2 ^ a3;
        mx[4*c+1] = a0 ^ x1 ^ (x2^a2) ^ a3;
        mx[4*c+2] = a0 ^ a1 ^ x2 ^ (x3^a3);
        mx[4*c+3] = (x0^a0) ^ a1 ^ a2 ^ x3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (skip_mix_i) begin
        state_o[127-8*i -: 8] = sb[i] ^ rkey_i[127-8*i -: 8];
      end else if (dec_i) begin
        state_o[127-8*i -: 8] = mx[i];
      end else begin
        state_o[127-8*i -: 8] = mx[i] ^ rkey_i[127-8*i -: 8];
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/aes_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aes_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);
  // A pending result holds its data until taken.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  // The block never takes an item while a result waits.
  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, m_axis_tvalid && s_axis_tready)
  // After accepting an item, the block is busy on the next cycle.
  `ASSERT_CLK(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
endmodule

bind aes_block_cipher aes_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
